// ----- rtl/fpr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the FIFO page replacement block.
// Used by fpr_cell, fifo_page_replacement and the testbench; depends on nothing else.

package fpr_pkg;

    // Number of physical frames and significant bits of a page number.
    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    // Fixed field widths of the stream beats.
    localparam int PAGE_NUMBER_W  = 16;
    localparam int FRAME_INDEX_W  = 3;
    localparam int TOTAL_W        = 32;

    // Stored page width: only the low PAGE_BITS bits of an access are used.
    localparam int PAGE_W     = (PAGE_BITS < PAGE_NUMBER_W) ? PAGE_BITS : PAGE_NUMBER_W;
    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int COUNT_BITS = $clog2(FRAMES + 1);

    // Result beat layout, lowest bit first.
    localparam int OUT_FIELDS_W = 1 + FRAME_INDEX_W + 1 + PAGE_NUMBER_W + 2 * TOTAL_W;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int S_TDATA_W    = ((PAGE_NUMBER_W + 7) / 8) * 8;

    // One slot of the replacement chain, youngest at cell 0.
    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] frame;
        logic [PAGE_W-1:0]     page;
    } entry_t;

endpackage

// ----- rtl/fpr_cell.sv -----
`timescale 1ns / 1ps
// One slot of the replacement chain: holds a page, its frame and a valid bit.
// Depends on fpr_pkg for the entry type.

module fpr_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic [fpr_pkg::PAGE_W-1:0]    lookup_page,
    input  fpr_pkg::entry_t               entry_in,
    output fpr_pkg::entry_t               entry_out,
    output logic                          match
);

    logic                           valid_reg;
    logic [fpr_pkg::FRAME_BITS-1:0] frame_reg;
    logic [fpr_pkg::PAGE_W-1:0]     page_reg;

    // Only the valid bit needs a reset; the payload is qualified by it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            frame_reg <= entry_in.frame;
            page_reg  <= entry_in.page;
        end
    end

    assign entry_out.valid = valid_reg;
    assign entry_out.frame = frame_reg;
    assign entry_out.page  = page_reg;

    assign match = valid_reg && (page_reg == lookup_page);

endmodule

// ----- rtl/fifo_page_replacement.sv -----
`timescale 1ns / 1ps
// Top level of the FIFO page replacement block: input stage, cell chain,
// counters and result register. Depends on fpr_pkg and fpr_cell.

// Usage:
// Each beat on the s_ channel is one page access (s_tdata holds page_number).
// Each access produces exactly one beat on the m_ channel carrying the hit
// flag, the frame now holding the page, the eviction flag and evicted page,
// and the saturating fault and hit totals after this access.
// The resident pages sit in a chain of cells ordered by load age, youngest
// in cell 0. All cells are compared against the page in parallel. A miss
// shifts the chain by one: the new page enters cell 0, and when all frames
// are in use the oldest page falls off the end and hands its frame over.
// An accepted beat is registered in the input stage and resolved against
// the chain once the result slot is free, which loads the result register.
// No new access is taken until the pending one has been resolved, so the
// chain update always lands before the next lookup.
// When the receiver stalls, the result register holds its beat, the pending
// access waits in the input stage, and s_tready stays low until it drains.
// A synchronous reset (aresetn low) empties all frames and clears the
// totals; no clearing pass is needed, so the block is ready right after.

module fifo_page_replacement (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: page_number[15:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpr_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: hit[0], frame_index[3:1], evicted[4], evicted_page[20:5],
    //          fault_total[52:21], hit_total[84:53], zero fill above
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpr_pkg::M_TDATA_W-1:0]   m_tdata
);

    // Input stage.
    logic                        pend_reg;
    logic                        pend_next;
    logic [fpr_pkg::PAGE_W-1:0]  page_reg;

    // Frame fill count and totals.
    logic [fpr_pkg::COUNT_BITS-1:0] fill_count_reg;
    logic [fpr_pkg::COUNT_BITS-1:0] fill_count_next;
    logic [fpr_pkg::TOTAL_W-1:0]    fault_total_reg;
    logic [fpr_pkg::TOTAL_W-1:0]    fault_total_next;
    logic [fpr_pkg::TOTAL_W-1:0]    hit_total_reg;
    logic [fpr_pkg::TOTAL_W-1:0]    hit_total_next;

    // Result register.
    logic                                m_tvalid_reg;
    logic                                m_tvalid_next;
    logic                                hit_reg;
    logic [fpr_pkg::FRAME_INDEX_W-1:0]   frame_index_reg;
    logic                                evicted_reg;
    logic [fpr_pkg::PAGE_NUMBER_W-1:0]   evicted_page_reg;

    // Chain.
    fpr_pkg::entry_t                 chain [fpr_pkg::FRAMES+1];
    logic [fpr_pkg::FRAMES-1:0]      match_vec;
    logic [fpr_pkg::FRAMES-1:0]      valid_vec;
    logic                            resolve;
    logic                            found;
    logic [fpr_pkg::FRAME_BITS-1:0]  hit_frame;
    logic                            full;
    fpr_pkg::entry_t                 oldest;
    logic [fpr_pkg::FRAME_BITS-1:0]  miss_frame;
    logic                            shift_en;

    // One access is resolved when it is pending and the result slot is free.
    assign resolve  = pend_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !pend_reg;

    assign full     = (fill_count_reg == fpr_pkg::COUNT_BITS'(fpr_pkg::FRAMES));
    assign oldest   = chain[fpr_pkg::FRAMES];
    assign shift_en = resolve && !found;

    // A free frame is always the next one in fill order; once all are in
    // use the oldest cell gives up its frame.
    assign miss_frame = full ? oldest.frame
                             : fill_count_reg[fpr_pkg::FRAME_BITS-1:0];

    assign chain[0].valid = 1'b1;
    assign chain[0].frame = miss_frame;
    assign chain[0].page  = page_reg;

    for (genvar g = 0; g < fpr_pkg::FRAMES; g++) begin : g_cell
        fpr_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (shift_en),
            .lookup_page (page_reg),
            .entry_in    (chain[g]),
            .entry_out   (chain[g+1]),
            .match       (match_vec[g])
        );
        assign valid_vec[g] = chain[g+1].valid;
    end

    // A page is resident in at most one cell; take the first match.
    always_comb begin
        found     = 1'b0;
        hit_frame = '0;
        for (int i = 0; i < fpr_pkg::FRAMES; i++) begin
            if (match_vec[i] && !found) begin
                found     = 1'b1;
                hit_frame = chain[i+1].frame;
            end
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (s_tvalid && s_tready) begin
            pend_next = 1'b1;
        end else if (resolve) begin
            pend_next = 1'b0;
        end
    end

    always_comb begin
        fill_count_next  = fill_count_reg;
        fault_total_next = fault_total_reg;
        hit_total_next   = hit_total_reg;
        if (resolve) begin
            if (found) begin
                if (hit_total_reg != '1) begin
                    hit_total_next = hit_total_reg + 1'b1;
                end
            end else begin
                if (fault_total_reg != '1) begin
                    fault_total_next = fault_total_reg + 1'b1;
                end
                if (!full) begin
                    fill_count_next = fill_count_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (resolve) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            fill_count_reg  <= '0;
            fault_total_reg <= '0;
            hit_total_reg   <= '0;
        end else begin
            pend_reg        <= pend_next;
            m_tvalid_reg    <= m_tvalid_next;
            fill_count_reg  <= fill_count_next;
            fault_total_reg <= fault_total_next;
            hit_total_reg   <= hit_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            page_reg <= s_tdata[fpr_pkg::PAGE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (resolve) begin
            hit_reg         <= found;
            frame_index_reg <= fpr_pkg::FRAME_INDEX_W'(found ? hit_frame : miss_frame);
            evicted_reg     <= !found && full;
            if (!found && full) begin
                evicted_page_reg <= fpr_pkg::PAGE_NUMBER_W'(oldest.page);
            end else begin
                evicted_page_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = fpr_pkg::M_TDATA_W'({hit_total_reg, fault_total_reg,
                                           evicted_page_reg, evicted_reg,
                                           frame_index_reg, hit_reg});

`ifndef ASSERT_OFF
    // The fill count never runs past the number of frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= fpr_pkg::COUNT_BITS'(fpr_pkg::FRAMES))
        else $error("fill count exceeds frame count");

    // The occupied cells are exactly the frames handed out so far.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(fill_count_reg))
        else $error("valid cells disagree with fill count");

    // A page is never resident in two frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $onehot0(match_vec))
        else $error("page matches more than one cell");

    // A resolved access always leaves a result beat behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        resolve |=> m_tvalid_reg)
        else $error("resolved access produced no result");

    // A miss with all frames in use must evict a valid page.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (resolve && !found && full) |-> oldest.valid)
        else $error("eviction from an empty cell");
`endif

endmodule

// ----- tb/fpr_access_checker.sv -----
`timescale 1ns / 1ps
// Checker for the FIFO page replacement block: watches both stream channels,
// predicts each result beat and compares it field by field. Depends on fpr_pkg.

module fpr_access_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fpr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fpr_pkg::M_TDATA_W-1:0] m_tdata,
    output int unsigned                   error_count,
    output int unsigned                   outstanding
);
    import fpr_pkg::*;

    typedef struct {
        logic                     hit;
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     evicted;
        logic [PAGE_NUMBER_W-1:0] evicted_page;
        logic [TOTAL_W-1:0]       fault_total;
        logic [TOTAL_W-1:0]       hit_total;
    } access_outcome_t;

    // Shadow copy of the frame table and the load-order FIFO.
    logic [PAGE_W-1:0]     held_page [FRAMES];
    logic                  loaded    [FRAMES];
    logic [FRAME_BITS-1:0] load_order[FRAMES];
    int unsigned           order_head;
    int unsigned           order_tail;
    int unsigned           order_count;
    logic [TOTAL_W-1:0]    faults_seen;
    logic [TOTAL_W-1:0]    hits_seen;

    access_outcome_t predicted_outcomes[$];

    function automatic logic [TOTAL_W-1:0] bump_saturating(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void append_frame(input int unsigned frame);
        if (order_count < FRAMES) begin
            load_order[order_tail % FRAMES] = frame[FRAME_BITS-1:0];
            order_tail = (order_tail + 1) % FRAMES;
            order_count++;
        end
    endfunction

    // Resolves one access against the shadow state and returns its result.
    function automatic access_outcome_t resolve_access(input logic [PAGE_W-1:0] page);
        access_outcome_t o;
        int unsigned     frame;
        bit              found;
        bit              placed;
        o = '{default: '0};
        frame = 0;
        found = 0;
        placed = 0;
        for (int i = 0; i < FRAMES; i++) begin
            if (!found && loaded[i] && held_page[i] == page) begin
                frame = i;
                found = 1;
            end
        end
        if (found) begin
            o.hit = 1'b1;
            hits_seen = bump_saturating(hits_seen);
        end else begin
            faults_seen = bump_saturating(faults_seen);
            for (int i = 0; i < FRAMES; i++) begin
                if (!placed && !loaded[i]) begin
                    frame = i;
                    held_page[i] = page;
                    loaded[i] = 1'b1;
                    append_frame(i);
                    placed = 1;
                end
            end
            if (!placed) begin
                // All frames in use: the oldest load gives up its frame.
                frame = load_order[order_head % FRAMES] % FRAMES;
                if (order_count > 0) begin
                    order_head = (order_head + 1) % FRAMES;
                    order_count--;
                end
                o.evicted = 1'b1;
                o.evicted_page = PAGE_NUMBER_W'(held_page[frame]);
                held_page[frame] = page;
                append_frame(frame);
            end
        end
        o.frame_index = frame[FRAME_INDEX_W-1:0];
        o.fault_total = faults_seen;
        o.hit_total = hits_seen;
        return o;
    endfunction

    function automatic int unsigned field_differs(input string name,
                                                  input logic [TOTAL_W-1:0] want,
                                                  input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch
        access_outcome_t want;
        int unsigned     bad;
        bad = 0;
        if (!aresetn) begin
            for (int i = 0; i < FRAMES; i++) begin
                held_page[i] = '0;
                loaded[i] = 1'b0;
                load_order[i] = '0;
            end
            order_head = 0;
            order_tail = 0;
            order_count = 0;
            faults_seen = '0;
            hits_seen = '0;
            predicted_outcomes.delete();
            error_count <= 0;
            outstanding <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_outcomes.push_back(resolve_access(s_tdata[PAGE_W-1:0]));
            if (m_tvalid && m_tready) begin
                if (predicted_outcomes.size() == 0) begin
                    $error("result beat with no access pending: m_tdata %0h", m_tdata);
                    bad = 1;
                end else begin
                    want = predicted_outcomes.pop_front();
                    bad += field_differs("hit", want.hit, m_tdata[0]);
                    bad += field_differs("frame_index", want.frame_index, m_tdata[3:1]);
                    bad += field_differs("evicted", want.evicted, m_tdata[4]);
                    bad += field_differs("evicted_page", want.evicted_page, m_tdata[20:5]);
                    bad += field_differs("fault_total", want.fault_total, m_tdata[52:21]);
                    bad += field_differs("hit_total", want.hit_total, m_tdata[84:53]);
                end
            end
            error_count <= error_count + bad;
            outstanding <= predicted_outcomes.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the FIFO page replacement testbench: clock, reset, access stimulus,
// result back-pressure and the verdict. Depends on fpr_pkg,
// fifo_page_replacement and fpr_access_checker.

module tb_top;
    import fpr_pkg::*;

    // Cycles without any accepted beat on either channel before giving up.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int          PHASES         = 14;
    localparam int          PHASE_ACCESSES = 100;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;

    int unsigned error_count;
    int unsigned outstanding;
    int unsigned idle_cycles = 0;

    // When set, neither side inserts gaps or stalls.
    bit calm = 1'b0;

    fifo_page_replacement dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fpr_access_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Offers one access beat after a random gap and holds it until accepted.
    // With no gap, s_tvalid simply stays high from the previous beat, so it
    // never receives two assignments in one time step.
    task automatic offer_page(input logic [PAGE_NUMBER_W-1:0] page);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(page);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds off the sender until the checker has nothing left to receive.
    // The checker's count is registered, so the task waits for an edge first.
    task automatic drain_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Stimulus: a directed opening, then random phases built around a small
    // pool of pages so that hits, fills and evictions all happen often.
    initial begin : stimulus
        logic [PAGE_NUMBER_W-1:0] opening[24];
        logic [PAGE_NUMBER_W-1:0] pool[$];
        logic [PAGE_NUMBER_W-1:0] page;
        int                       pool_size;

        // The first eight distinct pages fill the frames lowest first,
        // including both extremes of the page number. Then a hit on a full
        // table, and evictions that take the oldest load each time, among
        // them pages that were themselves evicted earlier.
        opening = '{16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001,
                    16'h0002, 16'h0004, 16'h8000, 16'h5555, 16'h7FFF, 16'h0000,
                    16'hFFFF, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                    16'h0000, 16'h1234, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening[i]) offer_page(opening[i]);
        drain_results;

        for (int p = 0; p < PHASES; p++) begin
            // Roughly one phase in four runs with no gaps or stalls at all.
            calm = ($urandom_range(0, 3) == 0);
            // Pools of eight or fewer mostly hit; larger ones thrash the FIFO.
            pool_size = $urandom_range(3, 14);
            pool.delete();
            repeat (pool_size) pool.push_back(PAGE_NUMBER_W'($urandom));
            for (int k = 0; k < PHASE_ACCESSES; k++) begin
                if ($urandom_range(0, 99) < 85)
                    page = pool[$urandom_range(0, pool.size() - 1)];
                else
                    page = PAGE_NUMBER_W'($urandom_range(0, 16'hFFFF));
                offer_page(page);
            end
            if (p % 4 == 3)
                drain_results;
        end

        drain_results;
        // Allow any stray beat that would follow the last result to show up.
        repeat (8) @(posedge aclk);
        if (error_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Receiver: a random stall before each result beat, none in calm phases.
    // As with the sender, m_tready stays high across back-to-back beats.
    initial begin : receiver
        int stall;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Watchdog: any accepted beat on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
